// ===== rtl/pcmsa_pkg.sv =====
// ----------------------------------------------------------------------------
// pcmsa_pkg : shared types and constants of the PCM slot allocator
// Field widths, status and register codes, the front item record, the
// divider request record and the back-end sequencer states.
// ----------------------------------------------------------------------------
package pcmsa_pkg;

  // Field widths
  localparam int BYTES_W    = 19;
  localparam int RATE_W     = 16;
  localparam int ADDR_W     = 19;
  localparam int PTR_W      = 20;
  localparam int SUM_W      = 21;
  localparam int SLOT_CNT_W = 7;
  localparam int SLOT_IDX_W = 6;
  localparam int PITCH_W    = 15;
  localparam int PLAY_W     = 18;
  localparam int BPB_W      = 12;
  localparam int STATUS_W   = 2;
  localparam int OCT_W      = 4;
  localparam int FRAC_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;

  // Chip output rate and the size limits
  localparam logic [RATE_W-1:0]  CHIP_RATE     = 16'd44100;
  localparam logic [BYTES_W-1:0] LIMIT_16      = 19'd131072;
  localparam logic [BYTES_W-1:0] LIMIT_8       = 19'd65536;
  localparam logic [ADDR_W-1:0]  RAM_END_RST   = 19'd522240;
  localparam logic [ADDR_W-1:0]  LOAD_BASE_RST = 19'd11304;
  localparam logic [7:0]         Q_SAT         = 8'd255;

  // Bytes per blank: x / fps equals (x * recip) >> BPB_SHIFT for any 17-bit x,
  // with recip = 2^23 / fps rounded up (50 frames for PAL, 60 otherwise).
  localparam int                 BPB_SHIFT  = 23;
  localparam int                 RECIP_W    = 18;
  localparam int                 BPB_PROD_W = RATE_W + 1 + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_PAL  = 18'd167773;
  localparam logic [RECIP_W-1:0] RECIP_NTSC = 18'd139811;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_REGION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_END    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_BASE  = 2'd2;

  // Shared divider geometry
  localparam int DIV_NW = 26;
  localparam int DIV_DW = 17;
  localparam int DIV_CW = $clog2(DIV_NW);

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_RAM_FULL   = 2'd1,
    STAT_TOO_BIG    = 2'd2,
    STAT_SLOTS_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic [BYTES_W-1:0] bytes;
    logic [PTR_W-1:0]   aligned;
    logic [RATE_W-1:0]  rate;
    logic               eight;
    logic               too_big;
  } fe_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_QDIV,
    BK_FPREP,
    BK_FDIV,
    BK_EMIT
  } back_state_t;

  // Bit length of an 8-bit value, zero for zero.
  function automatic logic [OCT_W-1:0] bit_len8(input logic [7:0] v);
    logic [OCT_W-1:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) n = OCT_W'(i + 1);
    end
    return n;
  endfunction

endpackage

// ===== rtl/pcmsa_div.sv =====
// ----------------------------------------------------------------------------
// pcmsa_div : shared restoring divider
// Unsigned division, one quotient bit per cycle; done pulses for one cycle
// after the last step with the quotient held until the next start.
// ----------------------------------------------------------------------------
module pcmsa_div
  import pcmsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [DIV_NW-1:0] num_r, num_nxt;
  logic [DIV_DW-1:0] den_r, den_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem_r, num_r[DIV_NW-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CW'(DIV_NW - 1);
      num_nxt  = req.dividend;
      den_nxt  = req.divisor;
      rem_nxt  = '0;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? DIV_DW'(trial - {1'b0, den_r}) : trial[DIV_DW-1:0];
      quo_nxt = {quo_r[DIV_NW-2:0], fits};
      num_nxt = {num_r[DIV_NW-2:0], 1'b0};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== rtl/pcmsa_front.sv =====
// ----------------------------------------------------------------------------
// pcmsa_front : request intake and classification
// Rounds the size up to four bytes, flags oversize requests and holds the
// classified requests in a short queue for the back end.
// ----------------------------------------------------------------------------
module pcmsa_front
  import pcmsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [BYTES_W-1:0] in_sample_bytes,
  input  logic [RATE_W-1:0]  in_sample_rate,
  input  logic               in_is_eight_bit,
  output logic               item_valid,
  output fe_item_t           item,
  input  logic               item_pop
);

  fe_item_t         q_mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             push_ok;
  logic             pop_ok;
  logic [PTR_W-1:0] padded;
  fe_item_t         new_item;

  assign in_full    = (cnt_r == QCW'(QDEPTH));
  assign item_valid = (cnt_r != '0);
  assign push_ok    = in_push && !in_full;
  assign pop_ok     = item_pop && item_valid;

  always_comb begin
    padded           = PTR_W'(in_sample_bytes) + PTR_W'(3);
    new_item.bytes   = in_sample_bytes;
    new_item.aligned = {padded[PTR_W-1:2], 2'b00};
    new_item.rate    = in_sample_rate;
    new_item.eight   = in_is_eight_bit;
    new_item.too_big = in_is_eight_bit ? (in_sample_bytes > LIMIT_8)
                                       : (in_sample_bytes > LIMIT_16);
  end

  always_comb begin
    wr_ptr_nxt = push_ok ? QAW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop_ok  ? QAW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCW'(push_ok) - QCW'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push_ok) q_mem_r[wr_ptr_r] <= new_item;
  end

  assign item = q_mem_r[rd_ptr_r];

endmodule

// ===== rtl/pcmsa_back.sv =====
// ----------------------------------------------------------------------------
// pcmsa_back : allocation sequencer
// Checks a request against the slot table and the load pointer, works out
// the pitch word on the shared divider and the bytes per blank by a
// reciprocal multiplication, and presents the result beat from an output
// register.
// ----------------------------------------------------------------------------
module pcmsa_back
  import pcmsa_pkg::*;
#(
  parameter int MAX_SLOTS = 64
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  item_valid,
  input  fe_item_t              item,
  output logic                  item_pop,
  output div_req_t              div_req,
  input  div_rsp_t              div_rsp,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [STATUS_W-1:0]   out_status,
  output logic [SLOT_IDX_W-1:0] out_slot_index,
  output logic [ADDR_W-1:0]     out_load_address,
  output logic [PITCH_W-1:0]    out_pitch_word,
  output logic [PLAY_W-1:0]     out_play_size,
  output logic [BPB_W-1:0]      out_bytes_per_blank,
  output logic                  out_depth_flag
);

  back_state_t             state_r, state_nxt;
  fe_item_t                it_r, it_nxt;
  status_t                 status_r, status_nxt;
  logic [OCT_W-1:0]        oct_r, oct_nxt;
  logic                    neg_r, neg_nxt;
  logic [FRAC_W-1:0]       frac_r, frac_nxt;
  logic [BPB_W-1:0]        bpb_r, bpb_nxt;
  logic                    pal_r;
  logic [ADDR_W-1:0]       ram_end_r;
  logic [PTR_W-1:0]        ptr_r;
  logic [SLOT_CNT_W-1:0]   slots_r;
  logic                    res_valid_r, res_valid_nxt;
  logic [STATUS_W-1:0]     res_status_r;
  logic [SLOT_IDX_W-1:0]   res_slot_r;
  logic [ADDR_W-1:0]       res_addr_r;
  logic [PITCH_W-1:0]      res_pitch_r;
  logic [PLAY_W-1:0]       res_play_r;
  logic [BPB_W-1:0]        res_bpb_r;
  logic                    res_depth_r;
  logic                    emit;
  logic                    ok;
  logic [7:0]              q_sat;
  logic [RATE_W-1:0]       shift_val;
  logic [RATE_W:0]         diff;
  logic [RATE_W-1:0]       mag;
  logic [SUM_W-1:0]        end_sum;
  logic [FRAC_W-1:0]       quo_lo;
  logic [RATE_W:0]         bpb_num;
  logic [RECIP_W-1:0]      recip;
  logic [BPB_PROD_W-1:0]   bpb_prod;

  assign ok        = (status_r == STAT_OK);
  assign emit      = (state_r == BK_EMIT) && (!res_valid_r || out_pop);
  assign q_sat     = (div_rsp.quotient > DIV_NW'(Q_SAT)) ? Q_SAT : div_rsp.quotient[7:0];
  assign shift_val = CHIP_RATE >> oct_r;
  assign diff      = {1'b0, it_r.rate} - {1'b0, shift_val};
  assign mag       = diff[RATE_W] ? RATE_W'(-diff) : diff[RATE_W-1:0];
  assign end_sum   = SUM_W'(ptr_r) + SUM_W'(it_r.bytes);
  assign quo_lo    = div_rsp.quotient[FRAC_W-1:0];
  // Sample bytes per second divided by the frame rate.
  assign bpb_num   = it_r.eight ? {1'b0, it_r.rate} : {it_r.rate, 1'b0};
  assign recip     = pal_r ? RECIP_PAL : RECIP_NTSC;
  assign bpb_prod  = BPB_PROD_W'(bpb_num) * BPB_PROD_W'(recip);

  always_comb begin
    state_nxt  = state_r;
    it_nxt     = it_r;
    status_nxt = status_r;
    oct_nxt    = oct_r;
    neg_nxt    = neg_r;
    frac_nxt   = frac_r;
    bpb_nxt    = bpb_r;
    item_pop   = 1'b0;
    div_req    = '0;
    unique case (state_r)
      BK_IDLE: begin
        if (item_valid) begin
          it_nxt    = item;
          item_pop  = 1'b1;
          state_nxt = BK_CHECK;
        end
      end
      BK_CHECK: begin
        priority if (slots_r >= SLOT_CNT_W'(MAX_SLOTS)) begin
          status_nxt = STAT_SLOTS_FULL;
        end else if (ptr_r > PTR_W'(ram_end_r)) begin
          status_nxt = STAT_RAM_FULL;
        end else if (it_r.too_big) begin
          status_nxt = STAT_TOO_BIG;
        end else if (end_sum > SUM_W'(ram_end_r)) begin
          status_nxt = STAT_RAM_FULL;
        end else begin
          status_nxt = STAT_OK;
        end
        if (status_nxt == STAT_OK) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_NW'(CHIP_RATE);
          div_req.divisor  = {1'b0, it_r.rate} + DIV_DW'(1);
          state_nxt        = BK_QDIV;
        end else begin
          state_nxt = BK_EMIT;
        end
      end
      BK_QDIV: begin
        if (div_rsp.done) begin
          oct_nxt   = bit_len8(q_sat);
          state_nxt = BK_FPREP;
        end
      end
      BK_FPREP: begin
        neg_nxt          = diff[RATE_W];
        div_req.start    = 1'b1;
        div_req.dividend = {mag, {FRAC_W{1'b0}}};
        div_req.divisor  = {1'b0, shift_val};
        state_nxt        = BK_FDIV;
      end
      BK_FDIV: begin
        if (div_rsp.done) begin
          // Truncation toward zero: negate the magnitude quotient.
          frac_nxt  = neg_r ? FRAC_W'(-quo_lo) : quo_lo;
          bpb_nxt   = bpb_prod[BPB_SHIFT +: BPB_W];
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (emit) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (emit) begin
      res_valid_nxt = 1'b1;
    end else if (out_pop) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      res_valid_r <= 1'b0;
      pal_r       <= 1'b0;
      ram_end_r   <= RAM_END_RST;
      ptr_r       <= PTR_W'(LOAD_BASE_RST);
      slots_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
      if (emit && ok) begin
        slots_r <= slots_r + 1'b1;
        ptr_r   <= ptr_r + it_r.aligned;
      end
      if (cfg_we) begin
        if (cfg_index == CFG_PAL_REGION) pal_r     <= cfg_wdata[0];
        if (cfg_index == CFG_RAM_END)    ram_end_r <= cfg_wdata;
        if (cfg_index == CFG_LOAD_BASE)  ptr_r     <= PTR_W'(cfg_wdata);
      end
    end
    it_r     <= it_nxt;
    status_r <= status_nxt;
    oct_r    <= oct_nxt;
    neg_r    <= neg_nxt;
    frac_r   <= frac_nxt;
    bpb_r    <= bpb_nxt;
    if (emit) begin
      res_status_r <= status_r;
      res_slot_r   <= ok ? slots_r[SLOT_IDX_W-1:0] : '0;
      res_addr_r   <= ok ? ptr_r[ADDR_W-1:0] : '0;
      res_pitch_r  <= ok ? {OCT_W'(5'd16 - {1'b0, oct_r}), 1'b0, frac_r} : '0;
      res_play_r   <= ok ? (it_r.eight ? it_r.aligned[PLAY_W-1:0]
                                       : it_r.aligned[PLAY_W:1]) : '0;
      res_bpb_r    <= ok ? bpb_r : '0;
      res_depth_r  <= ok ? it_r.eight : 1'b0;
    end
  end

  assign out_empty           = !res_valid_r;
  assign out_status          = res_status_r;
  assign out_slot_index      = res_slot_r;
  assign out_load_address    = res_addr_r;
  assign out_pitch_word      = res_pitch_r;
  assign out_play_size       = res_play_r;
  assign out_bytes_per_blank = res_bpb_r;
  assign out_depth_flag      = res_depth_r;

endmodule

// ===== rtl/pcm_slot_allocator_pitch_word_top.sv =====
// ----------------------------------------------------------------------------
// pcm_slot_allocator_pitch_word_top : PCM sample slot allocator
// Registers PCM samples in sound RAM and returns slot, address, pitch word,
// play size and bytes per video blank for each one.
// ----------------------------------------------------------------------------
// Each request beat (size in bytes, sample rate, 8-bit or 16-bit) yields
// exactly one result beat, in order. A request is checked in this order:
// a full slot table, a load pointer already past ram_end, a size over the
// limit (128 KiB for 16-bit, 64 KiB for 8-bit), then a sample end past
// ram_end; a failed check returns only the status, with every other field
// zero and the allocator state untouched. A granted sample gets the next
// slot number and the current load pointer, and the pointer then moves on
// by the size rounded up to four bytes. Requests are taken into a two-deep
// queue while the allocator works, so the producer is not held up by a
// single request in flight, and a finished result waits in an output
// register while the next request is already being worked on. For a granted
// request, the octave and the pitch fraction are two divisions of 26 steps
// each on a single shared one-bit-per-cycle divider, and the bytes per blank
// come from a reciprocal multiplication by the frame rate in the cycle that
// the fraction completes. A refused request skips both divisions.
// Configuration writes are meant for idle periods; writing load_base moves
// the load pointer at once and leaves the slot count alone.
// ----------------------------------------------------------------------------
module pcm_slot_allocator_pitch_word_top
  import pcmsa_pkg::*;
#(
  parameter int MAX_SLOTS = 64
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Request channel
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [BYTES_W-1:0]    in_sample_bytes,
  input  logic [RATE_W-1:0]     in_sample_rate,
  input  logic                  in_is_eight_bit,
  // Result channel
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [STATUS_W-1:0]   out_status,
  output logic [SLOT_IDX_W-1:0] out_slot_index,
  output logic [ADDR_W-1:0]     out_load_address,
  output logic [PITCH_W-1:0]    out_pitch_word,
  output logic [PLAY_W-1:0]     out_play_size,
  output logic [BPB_W-1:0]      out_bytes_per_blank,
  output logic                  out_depth_flag
);

  // Classified requests travel from the front to the sequencer.
  logic     item_valid;
  logic     item_pop;
  fe_item_t item;
  // The sequencer owns the shared divider.
  div_req_t div_req;
  div_rsp_t div_rsp;

  pcmsa_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_sample_bytes (in_sample_bytes),
    .in_sample_rate  (in_sample_rate),
    .in_is_eight_bit (in_is_eight_bit),
    .item_valid      (item_valid),
    .item            (item),
    .item_pop        (item_pop)
  );

  pcmsa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  pcmsa_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .item_valid          (item_valid),
    .item                (item),
    .item_pop            (item_pop),
    .div_req             (div_req),
    .div_rsp             (div_rsp),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_status          (out_status),
    .out_slot_index      (out_slot_index),
    .out_load_address    (out_load_address),
    .out_pitch_word      (out_pitch_word),
    .out_play_size       (out_play_size),
    .out_bytes_per_blank (out_bytes_per_blank),
    .out_depth_flag      (out_depth_flag)
  );

endmodule
